// ===== design/array_linked_list_engine_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the linked list engine
// Shorthand for clocked checks, disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef ARRAY_LINKED_LIST_ENGINE_UNIT_MACROS_SVH
`define ARRAY_LINKED_LIST_ENGINE_UNIT_MACROS_SVH

// same-cycle implication
`define ALLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ALLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/alle_pkg.sv =====
// ----------------------------------------------------------------------------
// alle_pkg
// Sizes, command codes, datapath operations and the controller/datapath types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package alle_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int PTR_W  = SLOT_W + 1;        // slot index plus the none code
  localparam int LEN_W  = $clog2(SLOTS + 1);
  localparam int KEY_W  = 32;
  localparam int CMD_W  = 3;

  localparam logic [PTR_W-1:0] NIL = PTR_W'(SLOTS);

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FIND   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FRONT  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_BACK   = 3'd5;

  typedef logic [3:0] op_t;

  // datapath operations
  localparam op_t OP_NONE     = 4'd0;
  localparam op_t OP_LOAD     = 4'd1;  // capture word, start walk at head
  localparam op_t OP_STEP     = 4'd2;  // one slot of the walk
  localparam op_t OP_TAKE     = 4'd3;  // pop free slot, store key, terminate it
  localparam op_t OP_LINK     = 4'd4;  // hang taken slot behind last, length up
  localparam op_t OP_UNLINK   = 4'd5;  // bypass found slot
  localparam op_t OP_FREE     = 4'd6;  // push found slot on free chain, length down
  localparam op_t OP_TO_FRONT = 4'd7;  // found slot becomes head
  localparam op_t OP_LAST_LNK = 4'd8;  // last slot points to found slot
  localparam op_t OP_TERM     = 4'd9;  // found slot points to none
  localparam op_t OP_RESULT   = 4'd10; // load output register

  typedef struct packed {
    op_t  op;
    logic ok;
  } ctrl_cmd_t;

  typedef struct packed {
    logic             walk_done;
    logic             hit;
    logic             free_avail;
    logic             prev_valid;
    logic             last_is_found;
    logic             out_busy;
    logic [CMD_W-1:0] cmd;
  } dp_status_t;

endpackage

// ===== design/alle_dpath.sv =====
// ----------------------------------------------------------------------------
// alle_dpath
// Slot arrays, list pointers, walk registers and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module alle_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  alle_pkg::ctrl_cmd_t           ctrl,
  output alle_pkg::dp_status_t          status,
  input  logic [alle_pkg::CMD_W-1:0]    in_cmd,
  input  logic [alle_pkg::KEY_W-1:0]    in_key,
  input  logic [alle_pkg::SLOT_W-1:0]   in_tgt,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_success,
  output logic [alle_pkg::SLOT_W-1:0]   out_slot,
  output logic [alle_pkg::LEN_W-1:0]    out_len
);
  import alle_pkg::*;

  // slot arrays
  logic [KEY_W-1:0] key_mem_r  [SLOTS];
  logic [PTR_W-1:0] next_mem_r [SLOTS];

  // captured word and walk state
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [SLOT_W-1:0] tgt_r, tgt_nxt;
  logic [PTR_W-1:0]  cur_r, cur_nxt, before_r, before_nxt;
  logic [PTR_W-1:0]  found_r, found_nxt, prev_r, prev_nxt, last_r, last_nxt;
  logic [LEN_W-1:0]  steps_r, steps_nxt;
  logic              hit_r, hit_nxt;

  // list pointers
  logic [PTR_W-1:0] head_r, head_nxt, free_r, free_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt, out_success_r, out_success_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [LEN_W-1:0]  out_len_r, out_len_nxt;

  // single read and write port on the link array
  logic [PTR_W-1:0] rd_ptr, rd_next;
  logic [KEY_W-1:0] rd_key;
  logic             nw_en, kw_en, match;
  logic [PTR_W-1:0] nw_addr, nw_data;

  always_comb begin
    unique case (ctrl.op)
      OP_TAKE:   rd_ptr = free_r;
      OP_UNLINK: rd_ptr = found_r;
      default:   rd_ptr = cur_r;
    endcase
  end

  assign rd_next = next_mem_r[rd_ptr[SLOT_W-1:0]];
  assign rd_key  = key_mem_r[cur_r[SLOT_W-1:0]];

  // compare by key or by slot, depending on the command
  always_comb begin
    unique case (cmd_r)
      CMD_INSERT, CMD_REMOVE, CMD_FIND: match = (rd_key == key_r);
      CMD_FRONT, CMD_BACK:              match = (cur_r == PTR_W'(tgt_r));
      default:                          match = 1'b0;
    endcase
  end

  // operation decode
  always_comb begin
    cmd_nxt = cmd_r; key_nxt = key_r; tgt_nxt = tgt_r;
    cur_nxt = cur_r; before_nxt = before_r; steps_nxt = steps_r;
    hit_nxt = hit_r; found_nxt = found_r; prev_nxt = prev_r; last_nxt = last_r;
    head_nxt = head_r; free_nxt = free_r; len_nxt = len_r;
    out_success_nxt = out_success_r; out_slot_nxt = out_slot_r; out_len_nxt = out_len_r;
    out_valid_nxt = out_valid_r && !out_ready;
    nw_en = 1'b0; nw_addr = found_r; nw_data = NIL; kw_en = 1'b0;
    unique case (ctrl.op)
      OP_LOAD: begin
        cmd_nxt = in_cmd; key_nxt = in_key; tgt_nxt = in_tgt;
        cur_nxt = head_r; before_nxt = NIL; steps_nxt = '0;
        hit_nxt = 1'b0; found_nxt = NIL; prev_nxt = NIL; last_nxt = NIL;
      end
      OP_STEP: begin
        if (!hit_r && match) begin
          hit_nxt = 1'b1; found_nxt = cur_r; prev_nxt = before_r;
        end
        last_nxt = cur_r; before_nxt = cur_r; cur_nxt = rd_next;
        steps_nxt = steps_r + LEN_W'(1);
      end
      OP_TAKE: begin
        free_nxt = rd_next; found_nxt = free_r; kw_en = 1'b1;
        nw_en = 1'b1; nw_addr = free_r; nw_data = NIL;
      end
      OP_LINK: begin
        if (last_r != NIL) begin
          nw_en = 1'b1; nw_addr = last_r; nw_data = found_r;
        end else begin
          head_nxt = found_r;
        end
        len_nxt = len_r + LEN_W'(1);
      end
      OP_UNLINK: begin
        if (prev_r != NIL) begin
          nw_en = 1'b1; nw_addr = prev_r; nw_data = rd_next;
        end else begin
          head_nxt = rd_next;
        end
      end
      OP_FREE: begin
        nw_en = 1'b1; nw_addr = found_r; nw_data = free_r;
        free_nxt = found_r; len_nxt = len_r - LEN_W'(1);
      end
      OP_TO_FRONT: begin
        nw_en = 1'b1; nw_addr = found_r; nw_data = head_r; head_nxt = found_r;
      end
      OP_LAST_LNK: begin
        nw_en = 1'b1; nw_addr = last_r; nw_data = found_r;
      end
      OP_TERM: begin
        nw_en = 1'b1; nw_addr = found_r; nw_data = NIL;
      end
      OP_RESULT: begin
        out_valid_nxt   = 1'b1;
        out_success_nxt = ctrl.ok;
        out_slot_nxt    = ctrl.ok ? found_r[SLOT_W-1:0] : '0;
        out_len_nxt     = len_r;
      end
      default: ;
    endcase
  end

  // control registers and link array
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= NIL;
      free_r      <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        next_mem_r[i] <= PTR_W'(i + 1);
      end
    end else begin
      head_r      <= head_nxt;
      free_r      <= free_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
      if (nw_en) begin
        next_mem_r[nw_addr[SLOT_W-1:0]] <= nw_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt; key_r <= key_nxt; tgt_r <= tgt_nxt;
    cur_r <= cur_nxt; before_r <= before_nxt; steps_r <= steps_nxt;
    hit_r <= hit_nxt; found_r <= found_nxt; prev_r <= prev_nxt; last_r <= last_nxt;
    out_success_r <= out_success_nxt; out_slot_r <= out_slot_nxt; out_len_r <= out_len_nxt;
    if (kw_en) begin
      key_mem_r[free_r[SLOT_W-1:0]] <= key_r;
    end
  end

  // status to the controller
  assign status.walk_done     = (cur_r >= NIL) || (steps_r == LEN_W'(SLOTS));
  assign status.hit           = hit_r;
  assign status.free_avail    = (free_r != NIL);
  assign status.prev_valid    = (prev_r != NIL);
  assign status.last_is_found = (last_r == found_r);
  assign status.out_busy      = out_valid_r && !out_ready;
  assign status.cmd           = cmd_r;

  assign out_valid   = out_valid_r;
  assign out_success = out_success_r;
  assign out_slot    = out_slot_r;
  assign out_len     = out_len_r;

endmodule

// ===== design/alle_ctrl.sv =====
// ----------------------------------------------------------------------------
// alle_ctrl
// Sequencer: accepts a word, runs the walk, then the pointer updates, then
// posts the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module alle_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  alle_pkg::dp_status_t  status,
  output alle_pkg::ctrl_cmd_t   ctrl
);
  import alle_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WALK   = 3'd1;
  localparam logic [2:0] S_LINK   = 3'd2;
  localparam logic [2:0] S_FREE   = 3'd3;
  localparam logic [2:0] S_FRONT  = 3'd4;
  localparam logic [2:0] S_LASTLN = 3'd5;
  localparam logic [2:0] S_TERM   = 3'd6;
  localparam logic [2:0] S_RESULT = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       ok_r, ok_nxt;
  op_t        op;

  always_comb begin
    state_nxt = state_r;
    ok_nxt    = ok_r;
    op        = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op = OP_LOAD; state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (!status.walk_done) begin
          op = OP_STEP;
        end else begin
          // walk finished: pick the update path or fail
          ok_nxt = 1'b0; state_nxt = S_RESULT;
          unique case (status.cmd)
            CMD_INSERT, CMD_APPEND: begin
              if ((status.cmd == CMD_APPEND || !status.hit) && status.free_avail) begin
                op = OP_TAKE; ok_nxt = 1'b1; state_nxt = S_LINK;
              end
            end
            CMD_REMOVE: begin
              if (status.hit) begin
                op = OP_UNLINK; ok_nxt = 1'b1; state_nxt = S_FREE;
              end
            end
            CMD_FIND: ok_nxt = status.hit;
            CMD_FRONT: begin
              if (status.hit && status.prev_valid) begin
                op = OP_UNLINK; ok_nxt = 1'b1; state_nxt = S_FRONT;
              end
            end
            CMD_BACK: begin
              if (status.hit && !status.last_is_found) begin
                op = OP_UNLINK; ok_nxt = 1'b1; state_nxt = S_LASTLN;
              end
            end
            default: ;
          endcase
        end
      end
      S_LINK:   begin op = OP_LINK;     state_nxt = S_RESULT; end
      S_FREE:   begin op = OP_FREE;     state_nxt = S_RESULT; end
      S_FRONT:  begin op = OP_TO_FRONT; state_nxt = S_RESULT; end
      S_LASTLN: begin op = OP_LAST_LNK; state_nxt = S_TERM;   end
      S_TERM:   begin op = OP_TERM;     state_nxt = S_RESULT; end
      S_RESULT: begin
        // hold until the output register can take the word
        if (!status.out_busy) begin
          op = OP_RESULT; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ok_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ok_r    <= ok_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign ctrl.op  = op;
  assign ctrl.ok  = ok_r;

endmodule

// ===== design/array_linked_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// array_linked_list_engine_unit
// Linked list of 32-bit keys in 16 slots with a free-slot chain. One command
// word in, one result word out. The list is walked one slot per cycle over
// the single read port of the link array. The first pointer update shares
// the cycle that ends the walk, and each further one is a state of its own:
// none more for find and for failed commands, one more for insert, append,
// remove and move to front, two more for move to back. A finished result
// waits in the output register while the next command is already taken; the
// next result then waits until that word is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "array_linked_list_engine_unit_macros.svh"

module array_linked_list_engine_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // key[31:0], target_slot[35:32], zero pad
  input  logic [2:0]  in_tuser,   // command[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // success[0], slot[4:1], length[9:5], zero pad
);
  import alle_pkg::*;

  ctrl_cmd_t         ctrl;
  dp_status_t        status;
  logic              out_success;
  logic [SLOT_W-1:0] out_slot;
  logic [LEN_W-1:0]  out_len;

  alle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .status   (status),
    .ctrl     (ctrl)
  );

  alle_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .status      (status),
    .in_cmd      (in_tuser),
    .in_key      (in_tdata[31:0]),
    .in_tgt      (in_tdata[35:32]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_success (out_success),
    .out_slot    (out_slot),
    .out_len     (out_len)
  );

  assign out_tdata = {6'd0, out_len, out_slot, out_success};

  // checks
  `ALLE_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "accepted twice")
  `ALLE_ASSERT_NOW(a_result_slot_free, ctrl.op == OP_RESULT, !status.out_busy, "result overrun")
  `ALLE_ASSERT_NOW(a_fail_slot_zero, out_tvalid && !out_tdata[0], out_tdata[4:1] == 4'd0, "slot on fail")
  `ALLE_ASSERT_NOW(a_len_bound, out_tvalid, out_tdata[9:5] <= 5'(SLOTS), "length overflow")

endmodule

// ===== tb/alle_list_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alle_list_checker
// Watches the command and result streams of the linked list engine. Keeps its
// own copy of the slot array, the link chain and the free chain, predicts the
// result of every accepted command word and compares each result word with the
// oldest prediction. Hands the failure count and the outstanding count to the
// test top.
// ----------------------------------------------------------------------------
module alle_list_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // key[31:0], target_slot[35:32], zero pad
  input  logic [2:0]  in_tuser,   // command[2:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // success[0], slot[4:1], length[9:5], zero pad
  output int          fail_count,
  output int          words_pending
);
  import alle_pkg::*;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  len;
  } list_result_t;

  // mirrored list state
  logic [KEY_W-1:0] key_mem  [SLOTS];
  logic [PTR_W-1:0] link_mem [SLOTS];
  logic [PTR_W-1:0] head_ptr;
  logic [PTR_W-1:0] free_ptr;
  logic [LEN_W-1:0] key_count;

  list_result_t predicted_q [$];
  int           mismatches;

  // walk the list from the head, bounded by SLOTS steps; reports the first
  // match, its predecessor and the tail
  function automatic logic locate(input logic by_key, input logic [KEY_W-1:0] want_key,
                                  input logic [PTR_W-1:0] want_slot,
                                  output logic [PTR_W-1:0] hit_slot,
                                  output logic [PTR_W-1:0] hit_prev,
                                  output logic [PTR_W-1:0] tail);
    logic [PTR_W-1:0] cur;
    logic [PTR_W-1:0] behind;
    logic             hit;
    int               steps;
    cur      = head_ptr;
    behind   = NIL;
    hit      = 1'b0;
    steps    = 0;
    hit_slot = NIL;
    hit_prev = NIL;
    tail     = NIL;
    while (cur < NIL && steps < SLOTS) begin
      if (!hit && (by_key ? (key_mem[cur[SLOT_W-1:0]] == want_key) : (cur == want_slot))) begin
        hit      = 1'b1;
        hit_slot = cur;
        hit_prev = behind;
      end
      tail   = cur;
      behind = cur;
      cur    = link_mem[cur[SLOT_W-1:0]];
      steps++;
    end
    return hit;
  endfunction

  // pop a free slot, store the key and hang it behind the tail
  function automatic logic take_free(input logic [KEY_W-1:0] key, input logic [PTR_W-1:0] tail,
                                     output logic [PTR_W-1:0] taken);
    taken = free_ptr;
    if (taken >= NIL) return 1'b0;
    free_ptr                       = link_mem[taken[SLOT_W-1:0]];
    key_mem[taken[SLOT_W-1:0]]     = key;
    link_mem[taken[SLOT_W-1:0]]    = NIL;
    if (tail < NIL) link_mem[tail[SLOT_W-1:0]] = taken;
    else head_ptr = taken;
    key_count++;
    return 1'b1;
  endfunction

  function automatic void bypass(input logic [PTR_W-1:0] s, input logic [PTR_W-1:0] prev);
    if (prev < NIL) link_mem[prev[SLOT_W-1:0]] = link_mem[s[SLOT_W-1:0]];
    else head_ptr = link_mem[s[SLOT_W-1:0]];
  endfunction

  function automatic list_result_t apply_list_command(input logic [CMD_W-1:0] cmd,
                                                      input logic [KEY_W-1:0] key,
                                                      input logic [SLOT_W-1:0] tgt);
    list_result_t     r;
    logic [PTR_W-1:0] hit_slot;
    logic [PTR_W-1:0] hit_prev;
    logic [PTR_W-1:0] tail;
    logic [PTR_W-1:0] taken;
    logic [PTR_W-1:0] want;
    logic             hit;
    r.ok  = 1'b0;
    taken = '0;
    want  = {1'b0, tgt};
    case (cmd)
      CMD_INSERT: begin
        hit = locate(1'b1, key, NIL, hit_slot, hit_prev, tail);
        if (!hit) r.ok = take_free(key, tail, taken);
      end
      CMD_APPEND: begin
        hit  = locate(1'b0, key, NIL, hit_slot, hit_prev, tail);
        r.ok = take_free(key, tail, taken);
      end
      CMD_REMOVE: begin
        if (locate(1'b1, key, NIL, hit_slot, hit_prev, tail)) begin
          bypass(hit_slot, hit_prev);
          link_mem[hit_slot[SLOT_W-1:0]] = free_ptr;
          free_ptr                       = hit_slot;
          key_count--;
          taken = hit_slot;
          r.ok  = 1'b1;
        end
      end
      CMD_FIND: begin
        if (locate(1'b1, key, NIL, hit_slot, hit_prev, tail)) begin
          taken = hit_slot;
          r.ok  = 1'b1;
        end
      end
      CMD_FRONT: begin
        if (locate(1'b0, key, want, hit_slot, hit_prev, tail) && hit_prev < NIL) begin
          link_mem[hit_prev[SLOT_W-1:0]] = link_mem[tgt];
          link_mem[tgt]                  = head_ptr;
          head_ptr                       = want;
          taken = want;
          r.ok  = 1'b1;
        end
      end
      CMD_BACK: begin
        if (locate(1'b0, key, want, hit_slot, hit_prev, tail) && tail != want) begin
          bypass(want, hit_prev);
          link_mem[tail[SLOT_W-1:0]] = want;
          link_mem[tgt]              = NIL;
          taken = want;
          r.ok  = 1'b1;
        end
      end
      default: ;  // spare codes do nothing
    endcase
    r.slot = r.ok ? taken[SLOT_W-1:0] : '0;
    r.len  = key_count;
    return r;
  endfunction

  // sample both channels at the rising edge
  always @(posedge clk) begin
    list_result_t want;
    list_result_t got;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        key_mem[i]  = '0;
        link_mem[i] = PTR_W'(i + 1);
      end
      head_ptr   = NIL;
      free_ptr   = '0;
      key_count  = '0;
      predicted_q.delete();
      mismatches = 0;
      fail_count = 0;
    end else begin
      if (in_tvalid && in_tready)
        predicted_q.push_back(apply_list_command(in_tuser, in_tdata[31:0], in_tdata[35:32]));
      if (out_tvalid && out_tready) begin
        got.ok   = out_tdata[0];
        got.slot = out_tdata[4:1];
        got.len  = out_tdata[9:5];
        if (predicted_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result word with nothing outstanding: ok=%0b slot=%0d len=%0d",
                     $realtime, got.ok, got.slot, got.len);
        end else begin
          want = predicted_q.pop_front();
          if (got.ok !== want.ok || got.slot !== want.slot || got.len !== want.len) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch: expected ok=%0b slot=%0d len=%0d, %s",
                       $realtime, want.ok, want.slot, want.len,
                       $sformatf("got ok=%0b slot=%0d len=%0d", got.ok, got.slot, got.len));
          end
        end
      end
      fail_count = mismatches;
    end
    words_pending = predicted_q.size();
  end

endmodule

// ===== tb/array_linked_list_engine_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_linked_list_engine_unit_test
// Drives command words into the linked list engine in random bursts while the
// result side stalls on its own pattern. A directed opening covers key
// extremes, duplicates, a full array, misses, moves of the head, the tail and
// free slots, and the spare codes; a long random run follows with keys from a
// small pool so that hits, removals and moves are frequent.
// ----------------------------------------------------------------------------
module array_linked_list_engine_unit_test;
  import alle_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
  localparam int POOL_SIZE   = 24;
  localparam int RANDOM_WORDS = 1520;

  // receiver modes
  localparam int SINK_OPEN   = 0;
  localparam int SINK_COIN   = 1;
  localparam int SINK_STALLS = 2;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;
  logic [2:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  int fail_count;
  int words_pending;
  int burst_left = 0;
  int sink_mode  = SINK_OPEN;
  int sink_left  = 0;
  int stall_left = 0;

  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  always #4 clk = ~clk;

  array_linked_list_engine_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  alle_list_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  // present one command word and hold it until accepted; bursts with gaps
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                           input logic [SLOT_W-1:0] tgt);
    int gap;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {4'b0000, tgt, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // command mix leans toward growing or shrinking the list
  function automatic logic [CMD_W-1:0] pick_cmd(input bit filling);
    int roll;
    roll = $urandom_range(0, 99);
    if (filling) begin
      if (roll < 35) return CMD_INSERT;
      if (roll < 55) return CMD_APPEND;
      if (roll < 65) return CMD_REMOVE;
      if (roll < 80) return CMD_FIND;
      if (roll < 88) return CMD_FRONT;
      if (roll < 96) return CMD_BACK;
    end else begin
      if (roll < 10) return CMD_INSERT;
      if (roll < 15) return CMD_APPEND;
      if (roll < 55) return CMD_REMOVE;
      if (roll < 73) return CMD_FIND;
      if (roll < 84) return CMD_FRONT;
      if (roll < 95) return CMD_BACK;
    end
    return $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
  endfunction

  // result side: open, coin-flip or long-stall stretches
  always @(negedge clk) begin
    if (sink_left == 0) begin
      sink_mode = $urandom_range(SINK_OPEN, SINK_STALLS);
      sink_left = $urandom_range(20, 200);
    end
    sink_left--;
    case (sink_mode)
      SINK_OPEN: out_tready <= 1'b1;
      SINK_COIN: out_tready <= 1'($urandom_range(0, 1));
      default: begin
        if (stall_left != 0) begin
          stall_left--;
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
          if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 12);
        end
      end
    endcase
  end

  // stimulus and verdict
  initial begin
    int  phase_left;
    bit  filling;
    filling    = 1'b1;
    phase_left = 0;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed opening
    send_word(CMD_FIND,   32'h0000_0005, 4'd0);   // miss on empty list
    send_word(CMD_FRONT,  32'h0000_0000, 4'd0);   // free slot
    send_word(CMD_INSERT, 32'h8000_0000, 4'd0);
    send_word(CMD_INSERT, 32'h7FFF_FFFF, 4'd15);
    send_word(CMD_INSERT, 32'h8000_0000, 4'd0);   // duplicate
    send_word(CMD_APPEND, 32'h8000_0000, 4'd0);   // duplicate allowed
    send_word(CMD_APPEND, 32'h0000_0000, 4'd0);
    send_word(CMD_INSERT, 32'hFFFF_FFFF, 4'd0);
    send_word(CMD_FRONT,  32'h0000_0000, 4'd0);   // head already in front
    send_word(CMD_BACK,   32'h0000_0000, 4'd4);   // tail already at back
    send_word(CMD_FRONT,  32'h0000_0000, 4'd3);
    send_word(CMD_BACK,   32'h0000_0000, 4'd3);
    send_word(CMD_FIND,   32'h8000_0000, 4'd0);
    send_word(CMD_REMOVE, 32'h8000_0000, 4'd0);
    send_word(CMD_REMOVE, 32'h1234_5678, 4'd0);   // missing key
    send_word(CMD_SPARE_LO, 32'h0000_0000, 4'd0);
    send_word(CMD_SPARE_HI, 32'hFFFF_FFFF, 4'd15);
    for (int i = 0; i < 13; i++) send_word(CMD_APPEND, $urandom, 4'd15);  // last one full
    send_word(CMD_INSERT, 32'h5A5A_5A5A, 4'd0);   // full array

    // random run
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (phase_left == 0) begin
        filling    = ~filling;
        phase_left = $urandom_range(30, 90);
      end
      phase_left--;
      if ($urandom_range(0, 49) == 0) key_pool[$urandom_range(4, POOL_SIZE - 1)] = $urandom;
      send_word(pick_cmd(filling), pick_key(), 4'($urandom_range(0, SLOTS - 1)));
    end
    in_tvalid <= 1'b0;

    while (words_pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (fail_count == 0 && words_pending == 0) begin
      $display("array_linked_list_engine_unit_test: PASS");
    end else begin
      $display("array_linked_list_engine_unit_test: FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #5000000;
    $display("array_linked_list_engine_unit_test: FAIL");
    $finish;
  end

endmodule

// ===== array_linked_list_engine_unit.f =====
+incdir+design
design/alle_pkg.sv
design/alle_dpath.sv
design/alle_ctrl.sv
design/array_linked_list_engine_unit.sv
tb/alle_list_checker.sv
tb/array_linked_list_engine_unit_test.sv
